// File: rtl/iqba_pkg.sv
// constants, register codes and helper function for the interval quadtree bin assigner
// used by interval_quadtree_bin_assign; no other dependencies
`timescale 1ns / 1ps

package iqba_pkg;

  localparam int MAX_LEVELS = 7;
  localparam int POS_BITS   = 32;
  localparam int LEN_W      = 33;
  localparam int LVL_W      = 3;
  localparam int BIN_W      = 15;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 32;
  // quotient bits needed for the deepest level: 2*levels plus one
  localparam int Q_W        = 2 * MAX_LEVELS + 1;
  localparam int WID_W      = LEN_W - 2;
  localparam int DSH_W      = WID_W + 2 * MAX_LEVELS;
  localparam int STEP_W     = $clog2(Q_W);
  localparam int SHF_W      = LVL_W + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;

  localparam int IN_DATA_W  = 2 * POS_BITS + TAG_W;
  localparam int OUT_RAW_W  = BIN_W + LVL_W + TAG_W + CNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16384);
  localparam logic [LVL_W-1:0] LVL_RESET = LVL_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTIG_LENGTH = 2'd0,
    CFG_NUM_LEVELS    = 2'd1
  } cfg_reg_t;

  // first global bin number of a level: 4^0 + ... + 4^(lvl-1)
  function automatic logic [BIN_W-1:0] level_offset(input logic [LVL_W-1:0] lvl);
    logic [BIN_W-1:0] off;
    off = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (k < int'(lvl)) begin
        off = off + (BIN_W'(1) << (2 * k));
      end
    end
    return off;
  endfunction

endpackage

// File: rtl/interval_quadtree_bin_assign.sv
// interval quadtree bin assigner: top level with sequencer and shared two-lane divider
// depends on iqba_pkg
`timescale 1ns / 1ps

// Usage
//   in_*  : one request per interval; in_tdata = start_pos, end_pos, block_id.
//   out_* : one result per request, in order; out_tuser flags out-of-range.
//   cfg_* : write contig_length (index 0) or num_levels (index 1) while idle.
// Each request walks the levels from the deepest upward. For every level a
// single restoring divider, with one subtract-compare lane for each end of
// the interval, produces both bin numbers one quotient bit per cycle.
// From acceptance, an out-of-range request or one with zero levels goes
// straight to the finish state; otherwise each visited level passes through
// setup, the divider loop and a check, and a level whose bin width is zero
// is skipped in setup. Results leave from the finish state.
// in_tready is high only while the sequencer is idle.
// A finished result sits in the output register; the next request can be
// taken while it waits, and a further result waits in the sequencer until
// out_tready frees the register. cfg_ready is always high.
// Reset (rst_n low, synchronous) clears the site counter and restores
// contig_length = 16384 and num_levels = 7.

module interval_quadtree_bin_assign (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_pos [31:0], end_pos [63:32], block_id [95:64]
  input  logic [iqba_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // bin_index [14:0], bin_level [17:15], block_tag [49:18], site_total [81:50], zero pad
  output logic [iqba_pkg::OUT_DATA_W-1:0]      out_tdata,
  // out_of_range [0]
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iqba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iqba_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PB  = iqba_pkg::POS_BITS;
  localparam int QW  = iqba_pkg::Q_W;
  localparam int DW  = iqba_pkg::DSH_W;
  localparam int LW  = iqba_pkg::LVL_W;
  localparam int BW  = iqba_pkg::BIN_W;
  localparam int CW  = iqba_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_CHECK,
    ST_FIN
  } state_t;

  state_t                         state_r, state_nxt;
  logic [iqba_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [LW-1:0]                  nlev_r, nlev_nxt;
  logic [PB-1:0]                  s_r, s_nxt, e_r, e_nxt;
  logic [iqba_pkg::TAG_W-1:0]     tag_r, tag_nxt;
  logic [LW-1:0]                  lvl_r, lvl_nxt;
  logic [DW-1:0]                  dsh_r, dsh_nxt;
  logic [PB-1:0]                  rs_r, rs_nxt, re_r, re_nxt;
  logic [QW-1:0]                  qs_r, qs_nxt, qe_r, qe_nxt;
  logic [iqba_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [BW-1:0]                  idx_r, idx_nxt;
  logic [LW-1:0]                  blvl_r, blvl_nxt;
  logic                           oor_r, oor_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic                           ovld_r, ovld_nxt;
  logic [BW-1:0]                  obin_r, obin_nxt;
  logic [LW-1:0]                  olvl_r, olvl_nxt;
  logic [iqba_pkg::TAG_W-1:0]     otag_r, otag_nxt;
  logic                           ooor_r, ooor_nxt;
  logic [CW-1:0]                  ocnt_r, ocnt_nxt;

  logic [PB-1:0]                  in_s, in_e;
  logic [iqba_pkg::TAG_W-1:0]     in_tag;
  logic                           in_oor;
  logic [LW-1:0]                  levels;
  logic [iqba_pkg::SHF_W-1:0]     shamt;
  logic [iqba_pkg::WID_W-1:0]     wid;
  logic                           ge_s, ge_e;
  logic [DW-1:0]                  sub_s, sub_e;
  logic [QW-1:0]                  nbins_m1, bf, bt;
  logic                           in_acc, cfg_acc;

  assign in_s   = in_tdata[PB-1:0];
  assign in_e   = in_tdata[2*PB-1:PB];
  assign in_tag = in_tdata[2*PB+iqba_pkg::TAG_W-1:2*PB];
  assign in_oor = ({1'b0, in_s} >= len_r) || ({1'b0, in_e} >= len_r);
  assign levels = (nlev_r > LW'(iqba_pkg::MAX_LEVELS)) ? LW'(iqba_pkg::MAX_LEVELS) : nlev_r;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // bin width of the current level and its top quotient bit position
  assign shamt = {lvl_r, 1'b0};
  assign wid   = iqba_pkg::WID_W'(len_r >> shamt);

  // shared divider lanes
  assign ge_s  = {{(DW-PB){1'b0}}, rs_r} >= dsh_r;
  assign ge_e  = {{(DW-PB){1'b0}}, re_r} >= dsh_r;
  assign sub_s = {{(DW-PB){1'b0}}, rs_r} - dsh_r;
  assign sub_e = {{(DW-PB){1'b0}}, re_r} - dsh_r;

  assign nbins_m1 = (QW'(1) << shamt) - QW'(1);
  assign bf = (qs_r > nbins_m1) ? nbins_m1 : qs_r;
  assign bt = (qe_r > nbins_m1) ? nbins_m1 : qe_r;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    nlev_nxt  = nlev_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    tag_nxt   = tag_r;
    lvl_nxt   = lvl_r;
    dsh_nxt   = dsh_r;
    rs_nxt    = rs_r;
    re_nxt    = re_r;
    qs_nxt    = qs_r;
    qe_nxt    = qe_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    blvl_nxt  = blvl_r;
    oor_nxt   = oor_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = ovld_r;
    obin_nxt  = obin_r;
    olvl_nxt  = olvl_r;
    otag_nxt  = otag_r;
    ooor_nxt  = ooor_r;
    ocnt_nxt  = ocnt_r;

    if (cfg_acc) begin
      case (cfg_index)
        iqba_pkg::CFG_CONTIG_LENGTH: len_nxt  = cfg_data;
        iqba_pkg::CFG_NUM_LEVELS:    nlev_nxt = cfg_data[LW-1:0];
        default: ;
      endcase
    end

    if (ovld_r && out_tready) begin
      ovld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          s_nxt    = in_s;
          e_nxt    = in_e;
          tag_nxt  = in_tag;
          oor_nxt  = in_oor;
          idx_nxt  = '0;
          blvl_nxt = '0;
          lvl_nxt  = levels;
          if (in_oor || levels == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        if (wid == '0) begin
          // bin narrower than one position: skip this level
          if (lvl_r == LW'(1)) begin
            state_nxt = ST_FIN;
          end else begin
            lvl_nxt = lvl_r - LW'(1);
          end
        end else begin
          dsh_nxt   = DW'(wid) << shamt;
          step_nxt  = iqba_pkg::STEP_W'(shamt);
          rs_nxt    = s_r;
          re_nxt    = e_r;
          qs_nxt    = '0;
          qe_nxt    = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (ge_s) rs_nxt = sub_s[PB-1:0];
        if (ge_e) re_nxt = sub_e[PB-1:0];
        qs_nxt  = {qs_r[QW-2:0], ge_s};
        qe_nxt  = {qe_r[QW-2:0], ge_e};
        dsh_nxt = dsh_r >> 1;
        step_nxt = step_r - iqba_pkg::STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (bf == bt) begin
          idx_nxt   = iqba_pkg::level_offset(lvl_r) + BW'(bf);
          blvl_nxt  = lvl_r;
          state_nxt = ST_FIN;
        end else if (lvl_r == LW'(1)) begin
          state_nxt = ST_FIN;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = ST_SETUP;
        end
      end
      ST_FIN: begin
        if (!ovld_r || out_tready) begin
          if (!oor_r && cnt_r != '1) begin
            cnt_nxt = cnt_r + CW'(1);
          end
          ovld_nxt  = 1'b1;
          obin_nxt  = idx_r;
          olvl_nxt  = blvl_r;
          otag_nxt  = tag_r;
          ooor_nxt  = oor_r;
          ocnt_nxt  = (!oor_r && cnt_r != '1) ? cnt_r + CW'(1) : cnt_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= iqba_pkg::LEN_RESET;
      nlev_r  <= iqba_pkg::LVL_RESET;
      cnt_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      nlev_r  <= nlev_nxt;
      cnt_r   <= cnt_nxt;
      ovld_r  <= ovld_nxt;
    end
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    tag_r  <= tag_nxt;
    lvl_r  <= lvl_nxt;
    dsh_r  <= dsh_nxt;
    rs_r   <= rs_nxt;
    re_r   <= re_nxt;
    qs_r   <= qs_nxt;
    qe_r   <= qe_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    blvl_r <= blvl_nxt;
    oor_r  <= oor_nxt;
    obin_r <= obin_nxt;
    olvl_r <= olvl_nxt;
    otag_r <= otag_nxt;
    ooor_r <= ooor_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tuser  = ooor_r;
  assign out_tdata  = {{(iqba_pkg::OUT_DATA_W - iqba_pkg::OUT_RAW_W){1'b0}},
                       ocnt_r, otag_r, olvl_r, obin_r};

  // divider never runs on a zero divisor or at the root level
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dsh_r != '0 && lvl_r != '0))
    else $error("divider running with zero divisor or at root");

  // out-of-range results carry the root bin
  a_oor_root: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && ooor_r) |-> (olvl_r == '0 && obin_r == '0))
    else $error("out-of-range result with non-root bin");

  // root level always means bin zero
  a_root_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && olvl_r == '0) |-> (obin_r == '0))
    else $error("root level with non-zero bin");

  // site counter only moves up by one as a result is loaded
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + CW'(1) && $past(state_r) == ST_FIN))
    else $error("site counter changed unexpectedly");

endmodule
